@@ rtl/swdtid_pkg.sv @@
// Shared types, constants and sequence tables for the SWD target ID reader.
package swdtid_pkg;

    localparam logic [8:0] SEQ_BITS  = 9'd264;
    localparam logic [7:0] REQ_TSEL  = 8'h99;
    localparam logic [7:0] REQ_DPIDR = 8'hA5;
    localparam logic [2:0] ACK_OK    = 3'h1;
    localparam logic [2:0] ACK_NONE  = 3'h7;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ACK_FAIL = 2'd1;
    localparam logic [1:0] STATUS_PARITY   = 2'd2;

    typedef enum logic [4:0] {
        PH_IDLE    = 5'd0,
        PH_SEQ     = 5'd1,
        PH_TSREQ   = 5'd2,
        PH_TURN_R1 = 5'd3,
        PH_TSACK   = 5'd4,
        PH_TURN_W1 = 5'd5,
        PH_TSDATA  = 5'd6,
        PH_TSPAR   = 5'd7,
        PH_IDREQ   = 5'd8,
        PH_TURN_R2 = 5'd9,
        PH_IDACK   = 5'd10,
        PH_TURN_F  = 5'd11,
        PH_ZEROS   = 5'd12,
        PH_IDDATA  = 5'd13,
        PH_IDPAR   = 5'd14,
        PH_TURN_E  = 5'd15,
        PH_LAST    = 5'd16
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [8:0]  bit_index;
        logic        host_drives;
        logic [31:0] target_word;
        logic [31:0] read_shift;
        logic [2:0]  ack_store;
        logic        parity_store;
        logic [1:0]  status_store;
    } t_state;

    typedef struct packed {
        logic        clock_pulse;
        logic        data_drive;
        logic        drive_enable;
        logic        busy_res;
        logic        done_res;
        logic [1:0]  status;
        logic [2:0]  ack_code;
        logic [31:0] id_word;
    } t_result;

    // Dormant wake-up stream, one byte per entry, sent least significant bit first.
    function automatic logic [7:0] wake_byte(input logic [5:0] idx);
        logic [5:0] k;
        k = (idx >= 6'd33) ? idx - 6'd33 : idx;
        case (k)
            6'd0:  wake_byte = 8'hff;
            6'd1:  wake_byte = 8'h75;
            6'd2:  wake_byte = 8'h77;
            6'd3:  wake_byte = 8'h77;
            6'd4:  wake_byte = 8'h67;
            6'd5:  wake_byte = 8'hff;
            6'd6:  wake_byte = 8'h92;
            6'd7:  wake_byte = 8'hf3;
            6'd8:  wake_byte = 8'h09;
            6'd9:  wake_byte = 8'h62;
            6'd10: wake_byte = 8'h95;
            6'd11: wake_byte = 8'h2d;
            6'd12: wake_byte = 8'h85;
            6'd13: wake_byte = 8'h86;
            6'd14: wake_byte = 8'he9;
            6'd15: wake_byte = 8'haf;
            6'd16: wake_byte = 8'hdd;
            6'd17: wake_byte = 8'he3;
            6'd18: wake_byte = 8'ha2;
            6'd19: wake_byte = 8'h0e;
            6'd20: wake_byte = 8'hbc;
            6'd21: wake_byte = 8'h19;
            6'd22: wake_byte = 8'ha0;
            6'd23: wake_byte = 8'hf1;
            6'd32: wake_byte = 8'h00;
            default: wake_byte = 8'hff;
        endcase
    endfunction

endpackage

@@ rtl/swd_target_id_reader.sv @@
// Top level of the SWD host sequencer that wakes a dormant target and reads its DPIDR.
//
// Each input beat is either a start command or one SWD bit period, and each
// produces exactly one result beat that tells how to drive the clock and data
// lines for that period and reports busy, done, status, acknowledge and the
// ID word. A beat is accepted in every cycle that has input ready high: the
// sequencer state advances in the cycle of acceptance and the result appears
// in the output register on the following cycle. Input ready drops only while
// that output register holds a result that the consumer has not taken.
module swd_target_id_reader
    import swdtid_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_func,
    input  logic [31:0] i_target_select,
    input  logic        i_line_sample,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_clock_pulse,
    output logic        o_data_drive,
    output logic        o_drive_enable,
    output logic        o_busy_res,
    output logic        o_done_res,
    output logic [1:0]  o_status,
    output logic [2:0]  o_ack_code,
    output logic [31:0] o_id_word
);

    t_state  r_state;
    t_state  n_state;
    t_result r_result;
    t_result n_result;
    logic    r_out_valid;
    logic    accept;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    swdtid_step u_step (
        .i_state         (r_state),
        .i_func          (i_func),
        .i_target_select (i_target_select),
        .i_line_sample   (i_line_sample),
        .o_next          (n_state),
        .o_result        (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase        <= PH_IDLE;
            r_state.bit_index    <= '0;
            r_state.host_drives  <= 1'b0;
            r_state.target_word  <= '0;
            r_state.read_shift   <= '0;
            r_state.ack_store    <= ACK_NONE;
            r_state.parity_store <= 1'b0;
            r_state.status_store <= STATUS_OK;
            r_out_valid          <= 1'b0;
        end else begin
            if (accept) begin
                r_state <= n_state;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_clock_pulse  = r_result.clock_pulse;
    assign o_data_drive   = r_result.data_drive;
    assign o_drive_enable = r_result.drive_enable;
    assign o_busy_res     = r_result.busy_res;
    assign o_done_res     = r_result.done_res;
    assign o_status       = r_result.status;
    assign o_ack_code     = r_result.ack_code;
    assign o_id_word      = r_result.id_word;

endmodule

@@ rtl/swdtid_step.sv @@
// Next-state and per-beat result logic of the SWD host sequencer.
module swdtid_step
    import swdtid_pkg::*;
(
    input  t_state      i_state,
    input  logic        i_func,
    input  logic [31:0] i_target_select,
    input  logic        i_line_sample,
    output t_state      o_next,
    output t_result     o_result
);

    always_comb begin
        t_state     n;
        logic       clk;
        logic       dd;
        logic       de;
        logic       done;
        logic       adv;
        logic       wrap;
        logic [8:0] adv_len;
        t_phase     adv_next;
        logic [8:0] bi_inc;
        logic [4:0] bi;
        logic [7:0] wb;

        n        = i_state;
        clk      = 1'b0;
        dd       = 1'b0;
        de       = 1'b0;
        done     = 1'b0;
        adv      = 1'b0;
        wrap     = 1'b0;
        adv_len  = 9'd1;
        adv_next = PH_IDLE;
        bi       = i_state.bit_index[4:0];
        wb       = wake_byte(i_state.bit_index[8:3]);
        bi_inc   = i_state.bit_index + 9'd1;

        if (i_func) begin
            if (i_state.phase == PH_IDLE) begin
                n.target_word  = i_target_select;
                n.read_shift   = '0;
                n.ack_store    = ACK_NONE;
                n.parity_store = 1'b0;
                n.status_store = STATUS_OK;
                n.bit_index    = '0;
                n.host_drives  = 1'b1;
                n.phase        = PH_SEQ;
                dd             = 1'b1;
                de             = 1'b1;
            end else begin
                de = i_state.host_drives;
            end
        end else if (i_state.phase != PH_IDLE) begin
            clk = 1'b1;
            adv = 1'b1;
            case (i_state.phase)
                PH_SEQ: begin
                    de       = 1'b1;
                    dd       = wb[i_state.bit_index[2:0]];
                    adv_len  = SEQ_BITS;
                    adv_next = PH_TSREQ;
                end
                PH_TSREQ: begin
                    de       = 1'b1;
                    dd       = REQ_TSEL[i_state.bit_index[2:0]];
                    adv_len  = 9'd8;
                    adv_next = PH_TURN_R1;
                end
                PH_TURN_R1: begin
                    n.host_drives = 1'b0;
                    adv_next      = PH_TSACK;
                end
                PH_TSACK: begin
                    adv_len  = 9'd3;
                    adv_next = PH_TURN_W1;
                end
                PH_TURN_W1: begin
                    n.host_drives = 1'b1;
                    adv_next      = PH_TSDATA;
                end
                PH_TSDATA: begin
                    de       = 1'b1;
                    dd       = i_state.target_word[bi];
                    adv_len  = 9'd32;
                    adv_next = PH_TSPAR;
                end
                PH_TSPAR: begin
                    de       = 1'b1;
                    dd       = ^i_state.target_word;
                    adv_next = PH_IDREQ;
                end
                PH_IDREQ: begin
                    de       = 1'b1;
                    dd       = REQ_DPIDR[i_state.bit_index[2:0]];
                    adv_len  = 9'd8;
                    adv_next = PH_TURN_R2;
                end
                PH_TURN_R2: begin
                    n.host_drives = 1'b0;
                    n.read_shift  = '0;
                    adv_next      = PH_IDACK;
                end
                PH_IDACK: begin
                    n.read_shift[i_state.bit_index[1:0]] =
                        i_state.read_shift[i_state.bit_index[1:0]] | i_line_sample;
                    adv_len  = 9'd3;
                    adv_next = PH_IDDATA;
                end
                PH_TURN_F: begin
                    n.host_drives = 1'b1;
                    adv_next      = PH_ZEROS;
                end
                PH_ZEROS: begin
                    de       = 1'b1;
                    adv_len  = 9'd32;
                    adv_next = PH_IDLE;
                end
                PH_IDDATA: begin
                    n.read_shift[bi] = i_state.read_shift[bi] | i_line_sample;
                    adv_len          = 9'd32;
                    adv_next         = PH_IDPAR;
                end
                PH_IDPAR: begin
                    n.parity_store = i_line_sample;
                    adv_next       = PH_TURN_E;
                end
                PH_TURN_E: begin
                    n.host_drives = 1'b1;
                    adv_next      = PH_LAST;
                end
                PH_LAST: begin
                    adv            = 1'b0;
                    de             = 1'b1;
                    n.status_store = (i_state.parity_store != ^i_state.read_shift)
                                     ? STATUS_PARITY : STATUS_OK;
                    n.host_drives  = 1'b0;
                    done           = 1'b1;
                    n.bit_index    = '0;
                    n.phase        = PH_IDLE;
                end
                default: begin
                    adv           = 1'b0;
                    clk           = 1'b0;
                    n.phase       = PH_IDLE;
                    n.bit_index   = '0;
                    n.host_drives = 1'b0;
                end
            endcase

            if (adv) begin
                n.bit_index = bi_inc;
                if (bi_inc >= adv_len) begin
                    n.bit_index = '0;
                    n.phase     = adv_next;
                    wrap        = 1'b1;
                end
            end

            if (wrap && i_state.phase == PH_IDACK) begin
                n.ack_store  = n.read_shift[2:0];
                n.read_shift = '0;
                if (n.read_shift[2:0] != ACK_OK && n.ack_store != ACK_OK) begin
                    n.phase = PH_TURN_F;
                end
            end
            if (wrap && i_state.phase == PH_ZEROS) begin
                n.status_store = STATUS_ACK_FAIL;
                n.host_drives  = 1'b0;
                done           = 1'b1;
            end
        end

        o_next                = n;
        o_result.clock_pulse  = clk;
        o_result.data_drive   = dd & de;
        o_result.drive_enable = de;
        o_result.busy_res     = (n.phase != PH_IDLE);
        o_result.done_res     = done;
        o_result.status       = n.status_store;
        o_result.ack_code     = n.ack_store;
        o_result.id_word      = (n.phase == PH_IDLE && n.status_store == STATUS_OK
                                 && n.ack_store == ACK_OK) ? n.read_shift : '0;
    end

endmodule
